FILE: rtl/f2c_pkg.sv
package f2c_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWAIT,
        ST_RD_START,
        ST_RD_NEXT,
        ST_RD_WAIT,
        ST_PREP,
        ST_CORDIC,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } f2c_state_t;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE  = 34'sd1073741824;

    // cordic vector path: 33-bit difference grows to about 35 bits
    localparam int VW = 36;
    // direction path
    localparam int RW = 34;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

FILE: rtl/frenet_to_cartesian_top.sv
// frenet to cartesian converter over a waypoint map held in block memories
// s_ channel: opcode 0 loads one waypoint (x, y, arc) at wp_index, no result;
// opcode 1 converts (path_s, lateral_d) and gives one m_ beat with out_x,
// out_y and segment_start.
// a load is written when taken and leaves the block idle. a convert reads the arc table one entry a cycle,
// stopping at the first arc not below path_s or at waypoint_count,
// then reads the two segment ends, runs CORDIC_STEPS iterations
// of one shared shift-add rotator, then four products on one 34x34
// multiplier and a sum step that loads the output register.
// s_ready is low while an item is in work; the next item is accepted once
// the result beat has left the output register.
// if m_ready stays low the result is held and no new item is taken.
// waypoint_count is written via cfg_we/cfg_wdata and read at each convert;
// it is clamped to 2..MAX_WAYPOINTS.
// reset (aresetn low, synchronous) returns to idle with waypoint_count = 2;
// the tables are not cleared and must be loaded before converting.
module frenet_to_cartesian_top #(
    parameter int MAX_WAYPOINTS = 256,
    parameter int CORDIC_STEPS  = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [7:0]         s_wp_index,
    input  logic signed [31:0] s_wp_x,
    input  logic signed [31:0] s_wp_y,
    input  logic [30:0]        s_wp_arc,
    input  logic signed [31:0] s_path_s,
    input  logic signed [31:0] s_lateral_d,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic [7:0]         m_segment_start
);
    import f2c_pkg::*;

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = AW + 1;
    localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic signed [31:0] mem_x [MAX_WAYPOINTS];
    logic signed [31:0] mem_y [MAX_WAYPOINTS];
    logic [30:0]        mem_s [MAX_WAYPOINTS];

    f2c_state_t state_reg, state_next;

    logic [8:0]  count_cfg_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] start_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;
    logic signed [31:0] rx_reg, ry_reg;
    logic [30:0] rs_reg;
    logic signed [31:0] x0_reg, y0_reg;
    logic [30:0] s0_reg;
    logic signed [31:0] ps_reg, pd_reg;
    logic        flip_reg, zero_reg;
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic signed [RW-1:0] cc_reg, ss_reg;
    logic [SW-1:0] step_reg;
    logic [1:0]  mcnt_reg;
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    logic signed [67:0] p_reg [4];
    logic signed [31:0] ox_reg, oy_reg;
    logic [7:0]  seg_reg;
    logic        mv_reg;

    logic [CW-1:0] count_clamp;
    always_comb begin
        if ({{(CW > 9 ? CW - 9 : 0){1'b0}}, count_cfg_reg} < CW'(2)) begin
            count_clamp = CW'(2);
        end else if (CW'(count_cfg_reg) > CW'(MAX_WAYPOINTS)
                     || (CW < 9 && count_cfg_reg > 9'(MAX_WAYPOINTS))) begin
            count_clamp = CW'(MAX_WAYPOINTS);
        end else begin
            count_clamp = CW'(count_cfg_reg);
        end
    end

    logic s_acc;
    assign s_acc = s_valid && s_ready;

    // memories: one write port, one registered read port
    logic wr_en;
    assign wr_en = s_acc && (s_opcode == OP_LOAD)
                   && ({1'b0, s_wp_index} < 9'(MAX_WAYPOINTS) || MAX_WAYPOINTS >= 256);
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[AW'(s_wp_index)] <= s_wp_x;
            mem_y[AW'(s_wp_index)] <= s_wp_y;
            mem_s[AW'(s_wp_index)] <= s_wp_arc;
        end
        if (rd_en) begin
            rx_reg <= mem_x[rd_addr];
            ry_reg <= mem_y[rd_addr];
            rs_reg <= mem_s[rd_addr];
        end
    end

    // search reads idx, data arrives in the next cycle; compare lags by one entry
    logic [CW-1:0] next_idx;
    assign next_idx = (CW'(start_reg) + CW'(1) == count_reg) ? '0 : CW'(start_reg) + CW'(1);

    // read data must hold the segment end from rd_next until prep
    always_comb begin
        rd_en = 1'b0;
        rd_addr = AW'(idx_reg);
        unique case (state_reg)
            ST_SEARCH:   rd_en = 1'b1;
            ST_SWAIT:    rd_en = 1'b1;
            ST_RD_START: begin
                rd_en = 1'b1;
                rd_addr = start_reg;
            end
            ST_RD_NEXT:  begin
                rd_en = 1'b1;
                rd_addr = AW'(next_idx);
            end
            default:     rd_en = 1'b0;
        endcase
    end

    logic s_gt;
    assign s_gt = $signed({1'b0, rs_reg}) < ps_reg;

    // shared rotator
    logic signed [VW-1:0] vxs, vys;
    logic signed [RW-1:0] ccs, sss;
    assign vxs = vx_reg >>> step_reg;
    assign vys = vy_reg >>> step_reg;
    assign ccs = cc_reg >>> step_reg;
    assign sss = ss_reg >>> step_reg;

    logic signed [VW-1:0] dxw, dyw;
    assign dxw = VW'(rx_reg) - VW'(x0_reg);
    assign dyw = VW'(ry_reg) - VW'(y0_reg);

    logic signed [RW-1:0] cf, sf;
    always_comb begin
        cf = (cc_reg > RW'(Q30_ONE)) ? RW'(Q30_ONE) :
             (cc_reg < -RW'(Q30_ONE)) ? -RW'(Q30_ONE) : cc_reg;
        sf = (ss_reg > RW'(Q30_ONE)) ? RW'(Q30_ONE) :
             (ss_reg < -RW'(Q30_ONE)) ? -RW'(Q30_ONE) : ss_reg;
        if (flip_reg) begin
            cf = -cf;
            sf = -sf;
        end
        if (zero_reg) begin
            cf = RW'(Q30_ONE);
            sf = '0;
        end
    end

    logic signed [33:0] seg;
    assign seg = 34'(ps_reg) - $signed({3'b0, s0_reg});

    // one multiplier, four uses: seg*c, d*s, seg*s, d*c
    always_comb begin
        unique case (mcnt_reg)
            2'd0:    begin ma = seg;         mb = cf; end
            2'd1:    begin ma = 34'(pd_reg); mb = sf; end
            2'd2:    begin ma = seg;         mb = sf; end
            default: begin ma = 34'(pd_reg); mb = cf; end
        endcase
    end
    assign prod = ma * mb;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_opcode == OP_CONVERT) state_next = ST_SEARCH;
            end
            ST_SEARCH:   state_next = ST_SWAIT;
            ST_SWAIT: begin
                if (!s_gt || idx_reg == count_reg) state_next = ST_RD_START;
            end
            ST_RD_START: state_next = ST_RD_NEXT;
            ST_RD_NEXT:  state_next = ST_RD_WAIT;
            ST_RD_WAIT:  state_next = ST_PREP;
            ST_PREP:     state_next = ST_CORDIC;
            ST_CORDIC: begin
                if (step_reg == SW'(CORDIC_STEPS - 1)) state_next = ST_MUL;
            end
            ST_MUL: begin
                if (mcnt_reg == 2'd3) state_next = ST_SUM;
            end
            ST_SUM:      state_next = ST_OUT;
            ST_OUT: begin
                if (!mv_reg) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE) && !mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_cfg_reg <= 9'd2;
            mv_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) count_cfg_reg <= cfg_wdata;
            if (state_reg == ST_SUM) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                idx_reg   <= '0;
                count_reg <= count_clamp;
                ps_reg    <= s_path_s;
                pd_reg    <= s_lateral_d;
            end
            ST_SEARCH: idx_reg <= idx_reg + CW'(1);
            ST_SWAIT: begin
                // rs_reg holds entry idx_reg-1
                if (!s_gt || idx_reg == count_reg) begin
                    if (!s_gt) begin
                        start_reg <= (idx_reg == CW'(1)) ? '0 : AW'(idx_reg - CW'(2));
                    end else begin
                        start_reg <= AW'(idx_reg - CW'(1));
                    end
                end else begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            ST_RD_START: ;
            ST_RD_NEXT: begin
                x0_reg <= rx_reg;
                y0_reg <= ry_reg;
                s0_reg <= rs_reg;
            end
            ST_RD_WAIT: ;
            ST_PREP: begin
                zero_reg <= (dxw == '0) && (dyw == '0);
                flip_reg <= dxw < 0;
                vx_reg   <= (dxw < 0) ? -dxw : dxw;
                vy_reg   <= (dxw < 0) ? -dyw : dyw;
                cc_reg   <= RW'(INV_GAIN);
                ss_reg   <= '0;
                step_reg <= '0;
            end
            ST_CORDIC: begin
                if (vy_reg >= 0) begin
                    vx_reg <= vx_reg + vys;
                    vy_reg <= vy_reg - vxs;
                    cc_reg <= cc_reg - sss;
                    ss_reg <= ss_reg + ccs;
                end else begin
                    vx_reg <= vx_reg - vys;
                    vy_reg <= vy_reg + vxs;
                    cc_reg <= cc_reg + sss;
                    ss_reg <= ss_reg - ccs;
                end
                step_reg <= step_reg + SW'(1);
                mcnt_reg <= 2'd0;
            end
            ST_MUL: begin
                p_reg[mcnt_reg] <= prod;
                mcnt_reg <= mcnt_reg + 2'd1;
            end
            ST_SUM: begin
                ox_reg  <= sat32(66'(x0_reg) + 66'((p_reg[0] + p_reg[1]
                           + 68'sd536870912) >>> 30));
                oy_reg  <= sat32(66'(y0_reg) + 66'((p_reg[2] - p_reg[3]
                           + 68'sd536870912) >>> 30));
                seg_reg <= 8'(start_reg);
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    assign m_valid         = mv_reg;
    assign m_out_x         = ox_reg;
    assign m_out_y         = oy_reg;
    assign m_segment_start = seg_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_valid_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(state_reg) == ST_SUM)
        else $error("result without compute");
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC) |-> step_reg < SW'(CORDIC_STEPS))
        else $error("cordic step overrun");

endmodule
